/* src/lssr_pkg.sv */
// Package for the search-and-remove stack: sizes, codes, command type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lssr_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);

  localparam int KIND_W = 2;
  localparam int VAL_W  = 32;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [WORD_BITS-1:0] word;
  } cmd_t;

endpackage

`default_nettype wire

/* src/lssr_if.sv */
// Channel interfaces for the stack: command beats in, result beats out.
// Depends on lssr_pkg for field widths.
`default_nettype none

interface lssr_in_if
  import lssr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lssr_out_if
  import lssr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [POS_W-1:0]         position;
  logic [STAT_W-1:0]        status;
  logic [FILL_W-1:0]        fill;

  modport source (output valid, output data_out, output position, output status,
                  output fill, input ready);
  modport sink   (input valid, input data_out, input position, input status,
                  input fill, output ready);
endinterface

`default_nettype wire

/* src/lssr_front.sv */
// Front end: accepts command beats, decodes the kind and trims the word.
// Depends on lssr_pkg and lssr_in_if.
`default_nettype none

module lssr_front
  import lssr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lssr_in_if.sink    in_bus,
  output logic       cmd_valid,
  input  wire logic  cmd_ready,
  output cmd_t       cmd
);

  logic v_r, v_nxt;
  cmd_t cmd_r;
  op_t  op_dec;

  always_comb begin
    unique case (in_bus.kind)
      KIND_PUSH:   op_dec = OP_PUSH;
      KIND_POP:    op_dec = OP_POP;
      KIND_SEARCH: op_dec = OP_SEARCH;
      default:     op_dec = OP_IGNORE;
    endcase
  end

  assign in_bus.ready = !v_r || cmd_ready;

  always_comb begin
    v_nxt = v_r;
    if (cmd_ready) v_nxt = 1'b0;
    if (in_bus.valid && in_bus.ready) v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Hold the payload until the queue takes it.
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cmd_r.op   <= op_dec;
      cmd_r.word <= WORD_BITS'($unsigned(in_bus.value));
    end
  end

  assign cmd_valid = v_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

/* src/lssr_queue.sv */
// Short command queue between the front end and the stack engine.
// Depends on lssr_pkg.
`default_nettype none

module lssr_queue
  import lssr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_cmd,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_cmd
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!do_wr && do_rd) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

`default_nettype wire

/* src/lssr_back.sv */
// Stack engine: cell array with per-cell compare, executes one command per
// cycle into a result register unless a result waits unread. Depends on lssr_pkg and lssr_out_if.
`default_nettype none

module lssr_back
  import lssr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  output logic       cmd_ready,
  input  wire cmd_t  cmd,
  lssr_out_if.source out_bus
);

  logic [WORD_BITS-1:0] cell_r [DEPTH];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_v_r, out_v_nxt;
  logic signed [DATA_W-1:0] data_r;
  logic [POS_W-1:0]     pos_r;
  logic [STAT_W-1:0]    stat_r;
  logic [FILL_W-1:0]    fill_r;

  logic                 exec;
  logic [DEPTH-1:0]     hit, hit_above;
  logic                 found, run;
  logic [IDX_W-1:0]     m_idx;
  logic [CNT_W-1:0]     top_cnt;
  logic [IDX_W-1:0]     top_idx;
  logic                 push_en, remove_en;
  logic [WORD_BITS-1:0] res_word;
  logic [CNT_W-1:0]     res_pos;
  logic [STAT_W-1:0]    res_stat;

  assign cmd_ready = !out_v_r || out_bus.ready;
  assign exec      = cmd_valid && cmd_ready;
  assign top_cnt   = cnt_r - CNT_W'(1);
  assign top_idx   = top_cnt[IDX_W-1:0];

  // Compare every live cell against the key at once.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      hit[j] = (CNT_W'(j) < cnt_r) && (cell_r[j] == cmd.word);
    end
  end

  // Mark cells with a hit somewhere above them; the match nearest the top
  // is the hit with none above.
  always_comb begin
    run = 1'b0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      hit_above[j] = run;
      run          = run | hit[j];
    end
  end

  always_comb begin
    m_idx = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (hit[j] && !hit_above[j]) m_idx = IDX_W'(j);
    end
  end

  assign found = |hit;

  always_comb begin
    cnt_nxt   = cnt_r;
    push_en   = 1'b0;
    remove_en = 1'b0;
    res_word  = '0;
    res_pos   = '0;
    res_stat  = ST_OK;
    unique case (cmd.op)
      OP_PUSH: begin
        if (cnt_r == CNT_W'(DEPTH)) begin
          res_stat = ST_FULL;
        end else begin
          push_en = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (cnt_r == '0) begin
          res_stat = ST_EMPTY;
        end else begin
          res_word = cell_r[top_idx];
          cnt_nxt  = top_cnt;
        end
      end
      OP_SEARCH: begin
        if (found) begin
          remove_en = 1'b1;
          res_word  = cell_r[m_idx];
          res_pos   = cnt_r - CNT_W'(m_idx);
          cnt_nxt   = top_cnt;
        end else begin
          res_stat = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_bus.ready) out_v_nxt = 1'b0;
    if (exec) out_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (exec) cnt_r <= cnt_nxt;
    end
  end

  // Push writes the slot above the top; remove closes the gap by moving
  // every cell at or above the match down by one.
  always_ff @(posedge clk) begin
    if (exec && push_en) cell_r[cnt_r[IDX_W-1:0]] <= cmd.word;
    for (int j = 0; j < DEPTH - 1; j++) begin
      if (exec && remove_en && !hit_above[j] && (IDX_W'(j) >= m_idx)) begin
        cell_r[j] <= cell_r[j + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      data_r <= DATA_W'($signed(res_word));
      pos_r  <= POS_W'(res_pos);
      stat_r <= res_stat;
      fill_r <= FILL_W'(cnt_nxt);
    end
  end

  assign out_bus.valid    = out_v_r;
  assign out_bus.data_out = data_r;
  assign out_bus.position = pos_r;
  assign out_bus.status   = stat_r;
  assign out_bus.fill     = fill_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (cmd.op == OP_PUSH) && (cnt_r != CNT_W'(DEPTH))
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (cmd.op == OP_SEARCH) && found |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("search hit did not shrink the stack");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (stat_r == ST_FULL) |-> fill_r == FILL_W'(DEPTH))
    else $error("full flagged with stack not full");

  a_fail_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (stat_r != ST_OK) |-> (pos_r == '0) && (data_r == '0))
    else $error("failed operation returned data");
`endif

endmodule

`default_nettype wire

/* src/lifo_stack_search_remove.sv */
// Top level of the bounded stack with search-and-remove.
// Depends on lssr_pkg, lssr_if, lssr_front, lssr_queue and lssr_back.
`default_nettype none

//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_bus   | in  | valid / ready | kind[1:0], value[31:0] signed
//  out_bus  | out | valid / ready | data_out[31:0], position[4:0],
//           |     |               | status[1:0], fill[4:0]
//
// One beat per cycle sustained while the output is not held off; every
// operation, search included, is executed combinationally by the stack
// engine, where each cell has its own comparator. An input beat passes the
// front register, the command queue and the result register, in that order.
// Reset is synchronous and clears the entry count and all handshake state;
// the cell contents are left undefined and are never read before written.
// A stalled result holds in the result register while the queue keeps
// taking beats; the front stalls only once the queue is full.

module lifo_stack_search_remove
  import lssr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lssr_in_if.sink    in_bus,
  lssr_out_if.source out_bus
);

  // front -> queue
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  // queue -> engine
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Decode and trim each beat.
  lssr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // Absorb engine stalls.
  lssr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  // Execute against the cell array and register the result.
  lssr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for lifo_stack_search_remove: push, pop and search beats in, results out.
// Depends on lssr_pkg, lssr_if and the block's top level; carries its own stack predictor.
`timescale 1ns / 1ps

module tb_top;
  import lssr_pkg::*;

  localparam int RANDOM_OPS = 1900;
  localparam int IDLE_PCT   = 21;
  localparam int CALM_FROM  = 600;   // window with no idling on either side
  localparam int CALM_TO    = 1100;
  localparam int HOLD_AT    = 1500;  // receiver holds off here, sender keeps going
  localparam int HOLD_LEN   = 90;
  localparam int DRAIN_WAIT = 8;     // idle wait after the last result, before the verdict

  // One command beat as queued for the driver.
  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } stack_cmd_t;

  // One result beat, field for field as on the output channel.
  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         position;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill;
  } stack_res_t;

  logic clk;
  logic rst_n;

  lssr_in_if  in_if ();
  lssr_out_if out_if ();

  lifo_stack_search_remove DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  // Bench-side copy of the stack contents, bottom at index 0.
  logic [WORD_BITS-1:0] shadow_cells [DEPTH];
  int                   shadow_held;

  stack_cmd_t cmd_backlog [$];   // beats still to be offered
  stack_res_t results_due [$];   // results predicted but not yet seen
  int         mismatches;
  int         cyc_count;
  int         hold_left;
  logic       calm;

  assign calm = (cyc_count >= CALM_FROM) && (cyc_count < CALM_TO);

  // Apply one operation to the shadow stack and return the result it should give.
  function automatic stack_res_t stack_apply(input op_t op, input logic signed [VAL_W-1:0] value);
    stack_res_t           r;
    logic [WORD_BITS-1:0] key;
    int                   hit;
    int                   i;
    r      = '0;
    r.status = ST_OK;
    key    = value[WORD_BITS-1:0];
    hit    = -1;
    case (op)
      OP_PUSH: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_cells[shadow_held] = key;
          shadow_held++;
        end
      end
      OP_POP: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_held--;
          r.data_out = $signed(shadow_cells[shadow_held]);
        end
      end
      OP_SEARCH: begin
        // scan from the top down; keep the first hit, i.e. the one nearest the top
        for (i = shadow_held - 1; i >= 0; i--) begin
          if (hit < 0 && shadow_cells[i] == key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.data_out = $signed(shadow_cells[hit]);
          r.position = POS_W'(shadow_held - hit);
          // close the gap, keeping the order of the rest
          for (i = hit; i + 1 < shadow_held; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_held--;
        end
      end
      default: ;  // unused code: no change, all-zero result but for the fill
    endcase
    r.fill = FILL_W'(shadow_held);
    return r;
  endfunction

  // Half the values come from a small pool so that searches find their keys.
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] pool [8];
    pool[0] = 32'sh0000_0000;
    pool[1] = -32'sd1;
    pool[2] = 32'sh8000_0000;
    pool[3] = 32'sh7fff_ffff;
    pool[4] = 32'sh0000_0001;
    pool[5] = 32'sh5555_5555;
    pool[6] = 32'shaaaa_aaaa;
    pool[7] = 32'sh1234_5678;
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $signed($urandom);
  endfunction

  task automatic add_cmd(input op_t op, input logic signed [VAL_W-1:0] value);
    stack_cmd_t c;
    c.op    = op;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  // Clock, reset, and known levels on every input from time zero.
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.kind   = '0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Free-running cycle count; drives the calm window and the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      cyc_count <= 0;
    end else begin
      cyc_count <= cyc_count + 1;
    end
  end

  // Driver: advance to the next beat once the current one is taken, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_if.valid <= 1'b1;
        in_if.kind  <= cmd_backlog[0].op;
        in_if.value <= cmd_backlog[0].value;
        void'(cmd_backlog.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Predict at the input handshake: each accepted beat yields exactly one result.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      results_due.push_back(stack_apply(op_t'(in_if.kind), in_if.value));
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the block fills and stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (cyc_count == HOLD_AT) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_LEN;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: compare every result beat with the oldest prediction.
  always @(posedge clk) begin
    stack_res_t got;
    stack_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.data_out = out_if.data_out;
      got.position = out_if.position;
      got.status   = out_if.status;
      got.fill     = out_if.fill;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result data=%0d pos=%0d status=%0d fill=%0d",
                 $time, got.data_out, got.position, got.status, got.fill);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected data=%0d pos=%0d status=%0d fill=%0d",
                   $time, want.data_out, want.position, want.status, want.fill);
          $display("%0t:          actual   data=%0d pos=%0d status=%0d fill=%0d",
                   $time, got.data_out, got.position, got.status, got.fill);
          mismatches++;
        end
      end
    end
  end

  // Stimulus, then drain and verdict.
  initial begin
    int   done_ops;
    int   mode;
    int   pick;
    int   k;
    op_t  op;
    mismatches  = 0;
    shadow_held = 0;
    done_ops    = 0;

    // Directed: empty-stack cases, the unused code, word extremes.
    add_cmd(OP_POP, 0);                    // pop on empty
    add_cmd(OP_SEARCH, 0);                 // search on empty: not found
    add_cmd(OP_IGNORE, -32'sd1);           // unused code, fill unchanged
    add_cmd(OP_PUSH, -32'sd1);
    add_cmd(OP_PUSH, 32'sh8000_0000);
    add_cmd(OP_PUSH, 32'sh7fff_ffff);
    add_cmd(OP_PUSH, 32'sh0000_0000);
    add_cmd(OP_SEARCH, 32'sh7fff_ffff);    // hit in the middle, order kept
    add_cmd(OP_SEARCH, -32'sd1);           // hit at the very bottom
    add_cmd(OP_SEARCH, 32'sd7);            // miss on a non-empty stack
    // Fill to the brim, then push on full.
    for (k = 0; k < DEPTH - 2; k++) add_cmd(OP_PUSH, 32'sd100 + 3 * k);
    add_cmd(OP_PUSH, 32'sd55);             // push on full
    add_cmd(OP_SEARCH, 32'sd100 + 3 * (DEPTH - 3));  // hit on top
    add_cmd(OP_SEARCH, 32'sh0000_0000);    // deep hit on a full-ish stack
    add_cmd(OP_POP, 0);

    // Random: blocks that lean to filling, draining or searching.
    while (done_ops < RANDOM_OPS) begin
      mode = $urandom_range(0, 2);
      for (k = 0; k < 32; k++) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0:       op = (pick < 65) ? OP_PUSH : (pick < 80) ? OP_POP :
                        (pick < 97) ? OP_SEARCH : OP_IGNORE;
          1:       op = (pick < 25) ? OP_PUSH : (pick < 65) ? OP_POP :
                        (pick < 97) ? OP_SEARCH : OP_IGNORE;
          default: op = (pick < 35) ? OP_PUSH : (pick < 55) ? OP_POP :
                        (pick < 97) ? OP_SEARCH : OP_IGNORE;
        endcase
        add_cmd(op, pick_value());
        if (op != OP_IGNORE) done_ops++;
      end
    end

    // Hold until every beat has gone in, then until every result is back.
    @(posedge clk);
    while (cmd_backlog.size() != 0 || in_if.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
